// ===== sv/bdph_pkg.sv =====
// Shared types and constants for the button debounce / press-hold block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdph_pkg;

    localparam int unsigned TIME_W    = 48;  // timestamp width, wraps mod 2^48
    localparam int unsigned MS_W      = 16;  // millisecond register width
    localparam int unsigned US_PER_MS = 1000;
    localparam int unsigned THR_W     = 26;  // holds 65535 * 1000
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS = 2'd0,
        CFG_HOLD_MS     = 2'd1,
        CFG_INVERT      = 2'd2
    } t_cfg_idx;

    localparam logic [THR_W-1:0] DEBOUNCE_US_RST = THR_W'(50 * US_PER_MS);
    localparam logic [THR_W-1:0] HOLD_US_RST     = THR_W'(1000 * US_PER_MS);

    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] now_us;
        logic              take_press;
        logic              take_hold;
    } t_sample;

    // Thresholds kept in microseconds, converted when the register is written.
    typedef struct packed {
        logic [THR_W-1:0] debounce_us;
        logic [THR_W-1:0] hold_us;
        logic             invert;
    } t_cfg;

    typedef struct packed {
        logic stable_level;
        logic press_seen;
        logic hold_seen;
    } t_result;

    function automatic logic [THR_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
        return THR_W'(32'(ms) * US_PER_MS);
    endfunction

endpackage

`default_nettype wire

// ===== sv/button_debounce_press_hold.sv =====
// Top level: channel handshakes, configuration registers, input and result registers.
// Depends on bdph_pkg and bdph_core.
`default_nettype none

// Push-button debouncer with sticky press and long-press (hold) flags. One sample
// enters per cycle through a valid/ready channel while the output is not stalled,
// and gives exactly one result through an input register, then the state update and
// result register. The sustained rate is one sample per clock while the output is not
// stalled, set by the state update in bdph_core; a stalled output holds one result and
// one more sample in the input register before o_in_ready drops. Configuration writes
// are always accepted; indexes beyond the register list are ignored. The millisecond
// registers are converted to microsecond thresholds at write time.
module button_debounce_press_hold
    import bdph_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // sample channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_raw_level,
    input  wire logic [TIME_W-1:0]    i_now_us,
    input  wire logic                 i_take_press,
    input  wire logic                 i_take_hold,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_stable_level,
    output logic                      o_press_seen,
    output logic                      o_hold_seen,
    // configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [MS_W-1:0]      i_cfg_data
);

    t_cfg    r_cfg, n_cfg;
    logic    r_in_valid, n_in_valid;
    t_sample r_sample, n_sample;
    logic    r_out_valid, n_out_valid;
    t_result r_result, n_result;

    logic    advance;
    logic    step;
    t_result core_result;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE_MS: n_cfg.debounce_us = ms_to_us(i_cfg_data);
                CFG_HOLD_MS:     n_cfg.hold_us     = ms_to_us(i_cfg_data);
                CFG_INVERT:      n_cfg.invert      = i_cfg_data[0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    // input register drains whenever the result register is free or being taken
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign step       = r_in_valid && advance;

    always_comb begin
        n_in_valid = o_in_ready ? i_in_valid : r_in_valid;
        n_sample   = r_sample;
        if (o_in_ready && i_in_valid) begin
            n_sample.raw_level  = i_raw_level;
            n_sample.now_us     = i_now_us;
            n_sample.take_press = i_take_press;
            n_sample.take_hold  = i_take_hold;
        end
        n_out_valid = advance ? r_in_valid : r_out_valid;
        n_result    = step ? core_result : r_result;
    end

    bdph_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_sample),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_us <= DEBOUNCE_US_RST;
            r_cfg.hold_us     <= HOLD_US_RST;
            r_cfg.invert      <= 1'b0;
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_result <= n_result;
    end

    assign o_out_valid    = r_out_valid;
    assign o_stable_level = r_result.stable_level;
    assign o_press_seen   = r_result.press_seen;
    assign o_hold_seen    = r_result.hold_seen;

endmodule

`default_nettype wire

// ===== sv/bdph_core.sv =====
// Debounce and press/hold state with the single-sample update logic.
// Depends on bdph_pkg.
`default_nettype none

module bdph_core
    import bdph_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_sample i_sample,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    logic              r_prev_level, n_prev_level;
    logic              r_debounced,  n_debounced;
    logic              r_press_flag, n_press_flag;
    logic              r_hold_flag,  n_hold_flag;
    logic [TIME_W-1:0] r_change_time, n_change_time;
    logic [TIME_W-1:0] r_press_start, n_press_start;

    logic              level;
    logic [TIME_W-1:0] settle_elapsed;
    logic [TIME_W-1:0] hold_elapsed;
    logic              settled;
    logic              edge_seen;
    logic              rise;
    logic              deb_now;
    logic              press_now;
    logic              hold_now;

    always_comb begin
        level          = i_sample.raw_level ^ i_cfg.invert;
        settle_elapsed = i_sample.now_us - r_change_time;
        hold_elapsed   = i_sample.now_us - r_press_start;

        // a level change restarts the timer and blocks settled, which needs an unchanged level
        settled   = (level == r_prev_level) &&
                    (settle_elapsed > TIME_W'(i_cfg.debounce_us));
        edge_seen = settled && (level != r_debounced);
        rise      = edge_seen && level;
        deb_now   = edge_seen ? level : r_debounced;
        press_now = rise || r_press_flag;

        // on a rising edge the press start is now, so hold cannot fire yet
        if (deb_now && !rise && (hold_elapsed > TIME_W'(i_cfg.hold_us))) begin
            hold_now = 1'b1;
        end else if (edge_seen) begin
            hold_now = 1'b0;
        end else begin
            hold_now = r_hold_flag;
        end
    end

    always_comb begin
        o_result.stable_level = deb_now;
        o_result.press_seen   = press_now;
        o_result.hold_seen    = hold_now;
    end

    always_comb begin
        n_prev_level  = r_prev_level;
        n_debounced   = r_debounced;
        n_press_flag  = r_press_flag;
        n_hold_flag   = r_hold_flag;
        n_change_time = r_change_time;
        n_press_start = r_press_start;
        if (i_step) begin
            n_prev_level = level;
            n_debounced  = deb_now;
            n_press_flag = press_now && !i_sample.take_press;
            n_hold_flag  = hold_now && !i_sample.take_hold;
            if (level != r_prev_level) begin
                n_change_time = i_sample.now_us;
            end
            if (rise) begin
                n_press_start = i_sample.now_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= 1'b0;
            r_debounced   <= 1'b0;
            r_press_flag  <= 1'b0;
            r_hold_flag   <= 1'b0;
            r_change_time <= '0;
            r_press_start <= '0;
        end else begin
            r_prev_level  <= n_prev_level;
            r_debounced   <= n_debounced;
            r_press_flag  <= n_press_flag;
            r_hold_flag   <= n_hold_flag;
            r_change_time <= n_change_time;
            r_press_start <= n_press_start;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bdph_checker.sv =====
// Port-level assertions for button_debounce_press_hold, attached by bind.
// Depends on bdph_pkg and the top level's port list.
`default_nettype none

module bdph_checker
    import bdph_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic              o_stable_level,
    input wire logic              o_press_seen,
    input wire logic              o_hold_seen
);

    // result channel holds a pending transaction unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_stable_level) && $stable(o_press_seen)
             && $stable(o_hold_seen)))
        else $error("result changed while stalled");

    // hold can only be reported while the debounced level is high
    a_hold_needs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hold_seen) |-> o_stable_level)
        else $error("hold reported with stable level low");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // no result without an earlier sample offered or a stalled input channel
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> $past(!o_in_ready || i_in_valid, 2) ||
                                 $past(i_in_valid && o_in_ready, 2))
        else $error("result appeared without a sample");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind button_debounce_press_hold bdph_checker u_bdph_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_stable_level (o_stable_level),
    .o_press_seen   (o_press_seen),
    .o_hold_seen    (o_hold_seen)
);

`default_nettype wire
